[sv/e2ews_pkg.sv]
// e2ews_pkg: shared constants and types for the e2e window state machine
// status codes, window defaults and the ring memory command word
// no dependencies
`default_nettype none

package e2ews_pkg;

	// default ring depth
	localparam int MAX_WINDOW = 16;

	// width of window sizes, ring top and tallies
	localparam int TOP_W = 5;

	typedef logic [2:0] status_t;

	// profile status codes
	localparam status_t ST_OK       = 3'd0;
	localparam status_t ST_ERROR    = 3'd3;
	localparam status_t ST_NOTAVAIL = 3'd4;
	localparam status_t ST_NONEW    = 3'd5;

	// command word from the control logic to the ring memory
	typedef struct packed {
		logic             we;
		logic [TOP_W-1:0] waddr;
		status_t          wdata;
		logic [TOP_W-1:0] raddr;
		logic             clr;
		logic [TOP_W-1:0] clr_cnt;
	} ring_cmd_t;

endpackage

`default_nettype wire

[sv/e2ews_ring.sv]
// e2ews_ring: status ring memory with per-entry valid bits
// unwritten or cleared entries read as not-available; read data registered
// depends on e2ews_pkg
`default_nettype none

module e2ews_ring #(
	parameter int MAX_WINDOW = e2ews_pkg::MAX_WINDOW
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  e2ews_pkg::ring_cmd_t cmd,
	output e2ews_pkg::status_t   rdata
);

	localparam int IDX_W = $clog2(MAX_WINDOW);
	localparam int CW = ((IDX_W > e2ews_pkg::TOP_W) ? IDX_W : e2ews_pkg::TOP_W) + 1;

	e2ews_pkg::status_t mem [MAX_WINDOW];
	logic [MAX_WINDOW-1:0] valid_q;
	e2ews_pkg::status_t rd_s1;
	logic rd_valid_s1;

	logic [CW-1:0] waddr_x;
	logic [CW-1:0] raddr_x;
	logic [IDX_W-1:0] widx;
	logic [IDX_W-1:0] ridx;
	logic w_in;

	// address mapping into the ring
	assign waddr_x = CW'(cmd.waddr);
	assign raddr_x = CW'(cmd.raddr);
	assign widx = waddr_x[IDX_W-1:0];
	assign ridx = raddr_x[IDX_W-1:0];
	assign w_in = cmd.we && (waddr_x < CW'(MAX_WINDOW));

	// storage write and registered read
	always_ff @(posedge clk) begin
		if (w_in) begin
			mem[widx] <= cmd.wdata;
		end
		rd_s1 <= mem[ridx];
	end

	// valid bits: clear sweeps a prefix at once, write marks one entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			for (int i = 0; i < MAX_WINDOW; i++) begin
				if (cmd.clr && (CW'(i) < CW'(cmd.clr_cnt))) begin
					valid_q[i] <= 1'b0;
				end else if (w_in && (widx == IDX_W'(i))) begin
					valid_q[i] <= 1'b1;
				end
			end
			rd_valid_s1 <= valid_q[ridx];
		end
	end

	// entries never written read as not available
	assign rdata = rd_valid_s1 ? rd_s1 : e2ews_pkg::ST_NOTAVAIL;

endmodule

`default_nettype wire

[sv/e2e_window_state_machine_unit.sv]
// e2e_window_state_machine_unit: top level of the e2e window state machine
// control sequencer, config registers and output register; ring in e2ews_ring
// depends on e2ews_pkg and e2ews_ring
//
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  s_tuser = action, s_tdata = profile_status
// m_*       out  m_tvalid/m_tready  m_tdata = return_code, state, ok, error totals
// cfg_*     in   cfg_we             cfg_addr = register index, cfg_wdata = value
//
// one word at a time: a check that recounts scans the window through the single ring read port,
// one entry per cycle, then drains the last read and decides
// init actions, rejected statuses, deinit checks and plain nodata checks skip the recount,
// a nodata check with extended transit to invalid skips it too and takes one decide step
// a new word is taken while the previous result waits in the output register
// m_tready low holds the finished result and stalls the sequencer before output
// arst_n puts the machine in deinit with an all not-available ring at once
`default_nettype none

module e2e_window_state_machine_unit #(
	parameter int MAX_WINDOW = e2ews_pkg::MAX_WINDOW
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_tvalid,
	output logic       s_tready,
	input  wire  [7:0] s_tdata,   // [2:0] profile_status, [7:3] zero
	input  wire        s_tuser,   // [0] action
	output logic       m_tvalid,
	input  wire        m_tready,
	output logic [15:0] m_tdata,  // [1:0] return_code, [4:2] machine_state,
	                              // [9:5] ok_total, [14:10] error_total, [15] zero
	input  wire        cfg_we,
	input  wire  [2:0] cfg_addr,
	input  wire  [9:0] cfg_wdata
);

	localparam int TW = e2ews_pkg::TOP_W;
	localparam logic [TW-1:0] MAX_SZ =
		(MAX_WINDOW >= 2**TW) ? {TW{1'b1}} : TW'(MAX_WINDOW);

	typedef enum logic [2:0] {
		MODE_VALID   = 3'd0,
		MODE_DEINIT  = 3'd1,
		MODE_NODATA  = 3'd2,
		MODE_INIT    = 3'd3,
		MODE_INVALID = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		RC_OK        = 2'd0,
		RC_WRONG_IN  = 2'd1,
		RC_WRONG_ST  = 2'd2
	} rc_t;

	typedef enum logic [2:0] {
		REG_WIN_INIT   = 3'd0,
		REG_WIN_VALID  = 3'd1,
		REG_WIN_INV    = 3'd2,
		REG_LIM_INIT   = 3'd3,
		REG_LIM_VALID  = 3'd4,
		REG_LIM_INV    = 3'd5,
		REG_CLR_INV    = 3'd6,
		REG_EXT_INV    = 3'd7
	} cfg_reg_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_STEP,
		S_RECOUNT,
		S_DRAIN,
		S_DECIDE,
		S_DONE
	} fsm_t;

	typedef struct packed {
		mode_t         nmode;
		logic          clr;
		logic [TW-1:0] clr_cnt;
		logic          clr_all;
	} decide_t;

	// configuration registers
	logic [TW-1:0] win_init_q, win_valid_q, win_inv_q;
	logic [9:0] lim_init_q, lim_valid_q, lim_inv_q;
	logic clr_inv_q, ext_inv_q;

	// machine state
	fsm_t state_q;
	mode_t mode_q;
	logic [TW-1:0] top_q, ok_q, err_q;
	logic [TW-1:0] idx_q, acc_ok_q, acc_err_q;
	logic rd_v_s1;
	logic act_q;
	e2ews_pkg::status_t st_q;
	rc_t rc_q;

	e2ews_pkg::ring_cmd_t cmd;
	e2ews_pkg::status_t rdata;

	logic [TW-1:0] ev, ei, eiv, szm, szf, ok_n, err_n;
	logic [TW-1:0] maxe_i, mino_i, maxe_v, mino_v, maxe_iv, mino_iv;
	logic out_init, pass_i, pass_iv, fail_v, slack_low, counts_st;
	logic do_write, quick_nodata;
	logic [TW:0] slack;
	decide_t dec;

	function automatic logic [TW-1:0] eff(input logic [TW-1:0] raw);
		logic [TW-1:0] r;
		if (raw == '0) begin
			r = TW'(1);
		end else if (raw > MAX_SZ) begin
			r = MAX_SZ;
		end else begin
			r = raw;
		end
		return r;
	endfunction

	// configuration write port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_init_q <= TW'(1);
			win_valid_q <= TW'(1);
			win_inv_q <= TW'(1);
			lim_init_q <= 10'd32;
			lim_valid_q <= 10'd32;
			lim_inv_q <= 10'd32;
			clr_inv_q <= 1'b0;
			ext_inv_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_addr))
				REG_WIN_INIT:  win_init_q <= cfg_wdata[TW-1:0];
				REG_WIN_VALID: win_valid_q <= cfg_wdata[TW-1:0];
				REG_WIN_INV:   win_inv_q <= cfg_wdata[TW-1:0];
				REG_LIM_INIT:  lim_init_q <= cfg_wdata;
				REG_LIM_VALID: lim_valid_q <= cfg_wdata;
				REG_LIM_INV:   lim_inv_q <= cfg_wdata;
				REG_CLR_INV:   clr_inv_q <= cfg_wdata[0];
				REG_EXT_INV:   ext_inv_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// effective window sizes and thresholds
	assign ev = eff(win_valid_q);
	assign ei = eff(win_init_q);
	assign eiv = eff(win_inv_q);
	assign maxe_i = lim_init_q[4:0];
	assign mino_i = lim_init_q[9:5];
	assign maxe_v = lim_valid_q[4:0];
	assign mino_v = lim_valid_q[9:5];
	assign maxe_iv = lim_inv_q[4:0];
	assign mino_iv = lim_inv_q[9:5];

	// window of the current mode, nodata counted as valid or as invalid
	always_comb begin
		case (mode_q)
			MODE_VALID:  begin szm = ev;  szf = ev;  end
			MODE_NODATA: begin szm = ev;  szf = eiv; end
			MODE_INIT:   begin szm = ei;  szf = ei;  end
			default:     begin szm = eiv; szf = eiv; end
		endcase
	end

	// tallies after the step; nodata keeps the old ones
	assign ok_n = (mode_q == MODE_NODATA) ? ok_q : acc_ok_q;
	assign err_n = (mode_q == MODE_NODATA) ? err_q : acc_err_q;

	// transition conditions, evaluated with the advanced ring top
	assign out_init = (top_q == '0) || (top_q >= ei);
	assign pass_i = (err_n <= maxe_i) && (ok_n >= mino_i);
	assign pass_iv = (err_n <= maxe_iv) && (ok_n >= mino_iv);
	assign fail_v = (err_n > maxe_v) || (ok_n < mino_v);
	assign slack = {1'b0, ok_n} + ({1'b0, ei} - {1'b0, top_q});
	assign slack_low = slack < {1'b0, mino_i};
	assign counts_st = (st_q != e2ews_pkg::ST_ERROR) && (st_q != e2ews_pkg::ST_NONEW);

	// next mode and window clearing
	always_comb begin
		logic go_inv, go_valid;
		go_inv = 1'b0;
		go_valid = 1'b0;
		dec = '{nmode: mode_q, clr: 1'b0, clr_cnt: '0, clr_all: 1'b0};
		case (mode_q)
			MODE_NODATA: begin
				if (out_init) begin
					go_inv = 1'b1;
				end else if (counts_st) begin
					dec.nmode = MODE_INIT;
				end
			end
			MODE_INIT: begin
				if (pass_i) begin
					go_valid = 1'b1;
				end else if ((err_n > maxe_i) || (ext_inv_q && (out_init || slack_low))) begin
					go_inv = 1'b1;
				end
			end
			MODE_VALID: begin
				if (fail_v) begin
					dec.nmode = MODE_INVALID;
					if (clr_inv_q) begin
						dec.clr = 1'b1;
						dec.clr_cnt = szf;
						dec.clr_all = 1'b1;
					end
				end
			end
			MODE_INVALID: begin
				if (pass_iv) begin
					go_valid = 1'b1;
				end
			end
			default: ;
		endcase
		if (go_inv) begin
			dec.nmode = MODE_INVALID;
			if (clr_inv_q) begin
				dec.clr = 1'b1;
				dec.clr_cnt = szf;
				dec.clr_all = 1'b1;
			end else if (szm < eiv) begin
				dec.clr = 1'b1;
				dec.clr_cnt = szm - TW'(1);
			end
		end
		if (go_valid) begin
			dec.nmode = MODE_VALID;
			if (szm < ev) begin
				dec.clr = 1'b1;
				dec.clr_cnt = szm - TW'(1);
			end
		end
	end

	// which step kind the held word is
	assign quick_nodata = (mode_q == MODE_NODATA) && !ext_inv_q;
	assign do_write = (state_q == S_STEP) && !act_q && (st_q <= e2ews_pkg::ST_NONEW)
		&& (mode_q != MODE_DEINIT) && !quick_nodata;

	// ring commands
	always_comb begin
		cmd.we = do_write;
		cmd.waddr = top_q;
		cmd.wdata = st_q;
		cmd.raddr = idx_q;
		cmd.clr = 1'b0;
		cmd.clr_cnt = szf;
		if ((state_q == S_STEP) && act_q) begin
			cmd.clr = 1'b1;
		end else if (state_q == S_DECIDE) begin
			cmd.clr = dec.clr;
			cmd.clr_cnt = dec.clr_cnt;
		end
	end

	e2ews_ring #(
		.MAX_WINDOW(MAX_WINDOW)
	) u_ring (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.rdata(rdata)
	);

	assign s_tready = (state_q == S_IDLE);

	// sequencer, machine state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mode_q <= MODE_DEINIT;
			top_q <= '0;
			ok_q <= '0;
			err_q <= '0;
			idx_q <= '0;
			acc_ok_q <= '0;
			acc_err_q <= '0;
			rd_v_s1 <= 1'b0;
			act_q <= 1'b0;
			st_q <= e2ews_pkg::ST_OK;
			rc_q <= RC_OK;
			m_tvalid <= 1'b0;
			m_tdata <= '0;
		end else begin
			rd_v_s1 <= (state_q == S_RECOUNT);
			// the done step reloads the output itself
			if (m_tvalid && m_tready && (state_q != S_DONE)) begin
				m_tvalid <= 1'b0;
			end
			// tally the word read in the previous cycle
			if (rd_v_s1) begin
				if (rdata == e2ews_pkg::ST_OK) begin
					acc_ok_q <= acc_ok_q + TW'(1);
				end
				if (rdata == e2ews_pkg::ST_ERROR) begin
					acc_err_q <= acc_err_q + TW'(1);
				end
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						act_q <= s_tuser;
						st_q <= s_tdata[2:0];
						state_q <= S_STEP;
					end
				end
				S_STEP: begin
					idx_q <= '0;
					acc_ok_q <= '0;
					acc_err_q <= '0;
					if (act_q) begin
						rc_q <= RC_OK;
						top_q <= '0;
						ok_q <= '0;
						err_q <= '0;
						mode_q <= MODE_NODATA;
						state_q <= S_DONE;
					end else if (st_q > e2ews_pkg::ST_NONEW) begin
						rc_q <= RC_WRONG_IN;
						state_q <= S_DONE;
					end else if (mode_q == MODE_DEINIT) begin
						rc_q <= RC_WRONG_ST;
						state_q <= S_DONE;
					end else if (quick_nodata) begin
						rc_q <= RC_OK;
						if (counts_st) begin
							mode_q <= MODE_INIT;
						end
						state_q <= S_DONE;
					end else begin
						rc_q <= RC_OK;
						// status written this cycle; advance the ring top
						if (top_q >= szm - TW'(1)) begin
							top_q <= '0;
						end else begin
							top_q <= top_q + TW'(1);
						end
						state_q <= (mode_q == MODE_NODATA) ? S_DECIDE : S_RECOUNT;
					end
				end
				S_RECOUNT: begin
					if (idx_q == szm - TW'(1)) begin
						state_q <= S_DRAIN;
					end else begin
						idx_q <= idx_q + TW'(1);
					end
				end
				S_DRAIN: begin
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					mode_q <= dec.nmode;
					ok_q <= dec.clr_all ? '0 : ok_n;
					err_q <= dec.clr_all ? '0 : err_n;
					if (dec.clr_all) begin
						top_q <= '0;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!m_tvalid || m_tready) begin
						m_tvalid <= 1'b1;
						m_tdata <= {1'b0, err_q, ok_q, mode_q, rc_q};
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// a taken word keeps the input closed on the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input ready right after an accepted word");

	// the ring is never written in deinit
	a_no_write_deinit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.we |-> mode_q != MODE_DEINIT)
		else $error("ring write in deinit mode");

	// tallies never exceed the largest window
	a_tally_bound: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, ok_q} + {1'b0, err_q}) <= {1'b0, MAX_SZ})
		else $error("tallies exceed window");

	// ring top stays inside the ring
	a_top_bound: assert property (@(posedge clk) disable iff (!arst_n)
		top_q < MAX_SZ)
		else $error("ring top out of range");

	// a result is loaded only from the done step
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q) == S_DONE)
		else $error("result raised outside done step");

endmodule

`default_nettype wire

[sim/e2ews_window_checker.sv]
// e2ews_window_checker: predicts and checks every result word of the e2e window state machine
// also holds e2ews_tb_pkg, the register, mode and return code names shared with the bench top
// depends on e2ews_pkg

package e2ews_tb_pkg;

	import e2ews_pkg::*;

	// config register indexes
	typedef enum logic [2:0] {
		REG_WINDOW_INIT,
		REG_WINDOW_VALID,
		REG_WINDOW_INVALID,
		REG_LIMITS_INIT,
		REG_LIMITS_VALID,
		REG_LIMITS_INVALID,
		REG_CLEAR_ON_INVALID,
		REG_EXTENDED_INVALID
	} cfg_reg_e;

	typedef enum logic [2:0] {
		MODE_VALID   = 3'd0,
		MODE_DEINIT  = 3'd1,
		MODE_NODATA  = 3'd2,
		MODE_INIT    = 3'd3,
		MODE_INVALID = 3'd4
	} mode_e;

	typedef enum logic [1:0] {
		RC_OK          = 2'd0,
		RC_BAD_STATUS  = 2'd1,
		RC_WRONG_STATE = 2'd2
	} ret_code_e;

	typedef enum logic {
		ACT_CHECK = 1'b0,
		ACT_INIT  = 1'b1
	} action_e;

	// status codes the package leaves out
	localparam status_t ST_REPEATED = 3'd1;
	localparam status_t ST_WRONGSEQ = 3'd2;
	localparam status_t ST_BAD_LO   = 3'd6;
	localparam status_t ST_BAD_HI   = 3'd7;

	// result word, lowest field last
	typedef struct packed {
		logic [4:0] error_total;
		logic [4:0] ok_total;
		mode_e      state;
		ret_code_e  code;
	} result_t;

endpackage

module e2ews_window_checker
	import e2ews_pkg::*;
	import e2ews_tb_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	input  wire         s_tready,
	input  wire  [7:0]  s_tdata,   // [2:0] profile_status, [7:3] zero
	input  wire         s_tuser,   // [0] action
	input  wire         m_tvalid,
	input  wire         m_tready,
	input  wire  [15:0] m_tdata,   // [1:0] return_code, [4:2] machine_state,
	                               // [9:5] ok_total, [14:10] error_total, [15] zero
	input  wire         cfg_we,
	input  wire  [2:0]  cfg_addr,
	input  wire  [9:0]  cfg_wdata,
	output int          open_words,
	output int          mismatches
);

	// predicted machine state
	mode_e   mode;
	status_t ring [MAX_WINDOW];
	int      top;
	int      oks;
	int      errs;

	// shadow config
	int win_init, win_valid, win_invalid;
	int lim_init, lim_valid, lim_invalid;
	bit clear_inv, ext_inv;

	result_t predicted_words [$];
	int      fail_total;

	function automatic int clamp_win(int raw);
		if (raw == 0)
			return 1;
		if (raw > MAX_WINDOW)
			return MAX_WINDOW;
		return raw;
	endfunction

	function automatic int max_errors(int lim);
		return lim & 31;
	endfunction

	function automatic int min_oks(int lim);
		return (lim >> 5) & 31;
	endfunction

	// window of the current mode; nodata counts as valid only on request
	function automatic int mode_window(bit nodata_as_valid);
		if (mode == MODE_VALID || (nodata_as_valid && mode == MODE_NODATA))
			return clamp_win(win_valid);
		if (mode == MODE_INIT)
			return clamp_win(win_init);
		return clamp_win(win_invalid);
	endfunction

	function automatic void mark_unavailable(int count);
		int i;
		for (i = 0; i < count && i < MAX_WINDOW; i++)
			ring[i] = ST_NOTAVAIL;
	endfunction

	// store at top, recount unless in nodata, advance top
	function automatic void store_status(status_t st);
		int span;
		int n_ok;
		int n_err;
		int i;
		span = clamp_win(win_valid);
		n_ok = 0;
		n_err = 0;
		if (top < MAX_WINDOW)
			ring[top] = st;
		if (mode != MODE_NODATA) begin
			span = mode_window(1'b0);
			for (i = 0; i < span; i++) begin
				if (ring[i] == ST_OK)
					n_ok++;
				if (ring[i] == ST_ERROR)
					n_err++;
			end
			oks = n_ok;
			errs = n_err;
		end
		if (top >= span - 1)
			top = 0;
		else
			top++;
	endfunction

	function automatic void wipe_window();
		mark_unavailable(mode_window(1'b0));
		oks = 0;
		errs = 0;
		top = 0;
	endfunction

	// partial clear when the next window is larger
	function automatic void trim_on_growth(mode_e next);
		int cur;
		int nxt;
		cur = mode_window(1'b1);
		nxt = (next == MODE_VALID) ? clamp_win(win_valid) : clamp_win(win_invalid);
		if (cur < nxt)
			mark_unavailable(cur - 1);
	endfunction

	function automatic void enter_invalid();
		if (clear_inv)
			wipe_window();
		else
			trim_on_growth(MODE_INVALID);
		mode = MODE_INVALID;
	endfunction

	function automatic bit top_past_init();
		return top == 0 || top >= clamp_win(win_init);
	endfunction

	// mode moves for one accepted status
	function automatic void apply_check(status_t st);
		case (mode)
			MODE_NODATA: begin
				if (ext_inv) begin
					store_status(st);
					if (top_past_init())
						enter_invalid();
					else if (st != ST_ERROR && st != ST_NONEW)
						mode = MODE_INIT;
				end else if (st != ST_ERROR && st != ST_NONEW) begin
					mode = MODE_INIT;
				end
			end
			MODE_INIT: begin
				store_status(st);
				if (errs <= max_errors(lim_init) && oks >= min_oks(lim_init)) begin
					trim_on_growth(MODE_VALID);
					mode = MODE_VALID;
				end else if (errs > max_errors(lim_init) ||
						(ext_inv && (top_past_init() ||
						oks + (clamp_win(win_init) - top) < min_oks(lim_init)))) begin
					enter_invalid();
				end
			end
			MODE_VALID: begin
				store_status(st);
				if (errs > max_errors(lim_valid) || oks < min_oks(lim_valid)) begin
					if (clear_inv)
						wipe_window();
					mode = MODE_INVALID;
				end
			end
			default: begin
				store_status(st);
				if (errs <= max_errors(lim_invalid) && oks >= min_oks(lim_invalid)) begin
					trim_on_growth(MODE_VALID);
					mode = MODE_VALID;
				end
			end
		endcase
	endfunction

	// one input word in, one result word out
	function automatic result_t advance_window_machine(action_e act, status_t st);
		result_t r;
		r.code = RC_OK;
		if (act == ACT_INIT) begin
			mark_unavailable(mode_window(1'b0));
			top = 0;
			oks = 0;
			errs = 0;
			mode = MODE_NODATA;
		end else if (st > ST_NONEW) begin
			r.code = RC_BAD_STATUS;
		end else if (mode == MODE_DEINIT) begin
			r.code = RC_WRONG_STATE;
		end else begin
			apply_check(st);
		end
		r.state = mode;
		r.ok_total = 5'(oks);
		r.error_total = 5'(errs);
		return r;
	endfunction

	function automatic void compare_field(string name, int want, int got);
		if (want != got) begin
			fail_total++;
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
		end
	endfunction

	// watch all three channels
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			mode = MODE_DEINIT;
			foreach (ring[i])
				ring[i] = ST_NOTAVAIL;
			top = 0;
			oks = 0;
			errs = 0;
			win_init = 1;
			win_valid = 1;
			win_invalid = 1;
			lim_init = 32;
			lim_valid = 32;
			lim_invalid = 32;
			clear_inv = 1'b0;
			ext_inv = 1'b0;
			predicted_words.delete();
			fail_total = 0;
			open_words <= 0;
			mismatches <= 0;
		end else begin
			// result words against the oldest prediction
			if (m_tvalid && m_tready) begin
				if (predicted_words.size() == 0) begin
					fail_total++;
					$display("%0t: result word expected none actual %h", $time, m_tdata);
				end else begin
					want = predicted_words.pop_front();
					compare_field("return_code", want.code, m_tdata[1:0]);
					compare_field("machine_state", want.state, m_tdata[4:2]);
					compare_field("ok_total", want.ok_total, m_tdata[9:5]);
					compare_field("error_total", want.error_total, m_tdata[14:10]);
				end
			end
			// register writes
			if (cfg_we) begin
				case (cfg_reg_e'(cfg_addr))
					REG_WINDOW_INIT:      win_init = cfg_wdata[4:0];
					REG_WINDOW_VALID:     win_valid = cfg_wdata[4:0];
					REG_WINDOW_INVALID:   win_invalid = cfg_wdata[4:0];
					REG_LIMITS_INIT:      lim_init = cfg_wdata;
					REG_LIMITS_VALID:     lim_valid = cfg_wdata;
					REG_LIMITS_INVALID:   lim_invalid = cfg_wdata;
					REG_CLEAR_ON_INVALID: clear_inv = cfg_wdata[0];
					REG_EXTENDED_INVALID: ext_inv = cfg_wdata[0];
					default: ;
				endcase
			end
			// accepted input words
			if (s_tvalid && s_tready)
				predicted_words.push_back(
					advance_window_machine(action_e'(s_tuser), status_t'(s_tdata[2:0])));
			open_words <= predicted_words.size();
			mismatches <= fail_total;
		end
	end

endmodule

[sim/e2e_window_state_machine_unit_tb.sv]
// e2e_window_state_machine_unit_tb: stimulus and verdict for the e2e window state machine
// drives status words and config writes, stalls both streams, checking lives in the checker
// depends on e2ews_pkg, e2e_window_state_machine_unit and e2ews_window_checker

module e2e_window_state_machine_unit_tb;

	import e2ews_pkg::*;
	import e2ews_tb_pkg::*;

	localparam int PHASES      = 8;
	localparam int PHASE_WORDS = 60;
	localparam int SETTLE      = 30;
	localparam int SQUEEZE     = 300;
	localparam int STALL_LIMIT = 2000;

	typedef struct packed {
		action_e act;
		status_t st;
	} word_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_addr = '0;
	logic [9:0]  cfg_wdata = '0;

	int open_words;
	int mismatches;
	int idle_cycles = 0;
	int hold_left = 0;
	int recv_idle_pct = 0;
	bit send_gaps = 1'b0;
	bit squeeze_req = 1'b0;
	bit squeeze_done = 1'b0;

	// deinit, rejection, nodata, init, valid and invalid walk at reset config
	word_t opening [18] = '{
		'{ACT_CHECK, ST_OK},       '{ACT_CHECK, ST_BAD_LO},   '{ACT_CHECK, ST_BAD_HI},
		'{ACT_CHECK, ST_NONEW},    '{ACT_INIT,  ST_BAD_HI},   '{ACT_CHECK, ST_ERROR},
		'{ACT_CHECK, ST_NONEW},    '{ACT_CHECK, ST_NOTAVAIL}, '{ACT_CHECK, ST_REPEATED},
		'{ACT_CHECK, ST_OK},       '{ACT_CHECK, ST_OK},       '{ACT_CHECK, ST_ERROR},
		'{ACT_CHECK, ST_WRONGSEQ}, '{ACT_CHECK, ST_BAD_LO},   '{ACT_CHECK, ST_OK},
		'{ACT_CHECK, ST_NOTAVAIL}, '{ACT_INIT,  ST_OK},       '{ACT_CHECK, ST_OK}
	};

	e2e_window_state_machine_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	e2ews_window_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.cfg_we     (cfg_we),
		.cfg_addr   (cfg_addr),
		.cfg_wdata  (cfg_wdata),
		.open_words (open_words),
		.mismatches (mismatches)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// mostly no gap, some short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// ok or error by bias, with other codes and rejected ones mixed in
	function automatic status_t pick_status(int ok_bias);
		int r;
		r = $urandom_range(0, 99);
		if (r < 4)
			return ($urandom_range(0, 1) != 0) ? ST_BAD_HI : ST_BAD_LO;
		if (r < 14) begin
			case ($urandom_range(0, 3))
				0: return ST_REPEATED;
				1: return ST_WRONGSEQ;
				2: return ST_NOTAVAIL;
				default: return ST_NONEW;
			endcase
		end
		return ($urandom_range(0, 99) < ok_bias) ? ST_OK : ST_ERROR;
	endfunction

	// mostly legal sizes, now and then zero or oversized
	function automatic int pick_window();
		if ($urandom_range(0, 9) == 0)
			return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(17, 31);
		return $urandom_range(1, 16);
	endfunction

	// limits that the window can reach, sometimes anything at all
	function automatic logic [9:0] make_limits(int win);
		int span;
		span = (win == 0) ? 1 : (win > MAX_WINDOW) ? MAX_WINDOW : win;
		if ($urandom_range(0, 5) == 0)
			return 10'($urandom_range(0, 1023));
		return {5'($urandom_range(0, span)), 5'($urandom_range(0, span))};
	endfunction

	// offer one word and hold it until taken
	task automatic push_word(input action_e act, input status_t st);
		int gap;
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= {5'b0, st};
		do
			@(posedge clk);
		while (!s_tready);
		gap = send_gaps ? pick_gap() : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// wait for every result, then let the block settle
	task automatic drain();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (open_words != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic load_config(input logic [9:0] vals [8]);
		int idx;
		for (idx = 0; idx < 8; idx++) begin
			cfg_we <= 1'b1;
			cfg_addr <= cfg_reg_e'(idx);
			cfg_wdata <= vals[idx];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	// receiver: random stalls plus one long hold-off
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else if (squeeze_req && !squeeze_done) begin
			squeeze_done <= 1'b1;
			hold_left <= SQUEEZE;
			m_tready <= 1'b0;
		end else if ($urandom_range(0, 99) < recv_idle_pct) begin
			hold_left <= pick_gap();
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// watchdog on cycles with no transfer anywhere
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// stimulus
	initial begin
		logic [9:0] vals [8];
		int phase;
		int n;
		int ok_bias;
		int wins [3];
		int k;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// opening walk at reset config
		recv_idle_pct <= 20;
		send_gaps <= 1'b1;
		foreach (opening[i])
			push_word(opening[i].act, opening[i].st);
		drain();

		for (phase = 0; phase < PHASES; phase++) begin
			// config for this phase, extremes first
			case (phase)
				0: begin
					for (k = 0; k < 3; k++)
						wins[k] = MAX_WINDOW;
					vals[REG_LIMITS_INIT] = '0;
					vals[REG_LIMITS_VALID] = '0;
					vals[REG_LIMITS_INVALID] = '0;
					vals[REG_CLEAR_ON_INVALID] = 10'd0;
					vals[REG_EXTENDED_INVALID] = 10'd0;
				end
				1: begin
					for (k = 0; k < 3; k++)
						wins[k] = 31;
					vals[REG_LIMITS_INIT] = '1;
					vals[REG_LIMITS_VALID] = '1;
					vals[REG_LIMITS_INVALID] = '1;
					vals[REG_CLEAR_ON_INVALID] = 10'd1;
					vals[REG_EXTENDED_INVALID] = 10'd1;
				end
				2: begin
					for (k = 0; k < 3; k++)
						wins[k] = 0;
					vals[REG_LIMITS_INIT] = make_limits(1);
					vals[REG_LIMITS_VALID] = make_limits(1);
					vals[REG_LIMITS_INVALID] = make_limits(1);
					vals[REG_CLEAR_ON_INVALID] = 10'd1;
					vals[REG_EXTENDED_INVALID] = 10'd0;
				end
				default: begin
					for (k = 0; k < 3; k++)
						wins[k] = pick_window();
					vals[REG_LIMITS_INIT] = make_limits(wins[0]);
					vals[REG_LIMITS_VALID] = make_limits(wins[1]);
					vals[REG_LIMITS_INVALID] = make_limits(wins[2]);
					vals[REG_CLEAR_ON_INVALID] = 10'($urandom_range(0, 1));
					vals[REG_EXTENDED_INVALID] = 10'($urandom_range(0, 1));
				end
			endcase
			vals[REG_WINDOW_INIT] = 10'(wins[0]);
			vals[REG_WINDOW_VALID] = 10'(wins[1]);
			vals[REG_WINDOW_INVALID] = 10'(wins[2]);
			load_config(vals);

			// idling pattern, one phase with a full input and a held output
			recv_idle_pct <= (phase % 3 == 0) ? 0 : 30;
			send_gaps <= (phase % 4 != 1) && (phase != 3);
			if (phase == 3)
				squeeze_req <= 1'b1;

			// well-formed runs: init then statuses with a drifting ok bias
			push_word(ACT_INIT, status_t'($urandom_range(0, 7)));
			ok_bias = 50;
			for (n = 0; n < PHASE_WORDS; n++) begin
				if (n % 15 == 0) begin
					case ($urandom_range(0, 3))
						0: ok_bias = 97;
						1: ok_bias = 3;
						2: ok_bias = 50;
						default: ok_bias = 80;
					endcase
				end
				if ($urandom_range(0, 99) < 3)
					push_word(ACT_INIT, status_t'($urandom_range(0, 7)));
				else
					push_word(ACT_CHECK, pick_status(ok_bias));
			end
			drain();
		end

		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

[filelist.f]
sv/e2ews_pkg.sv
sv/e2ews_ring.sv
sv/e2e_window_state_machine_unit.sv
sim/e2ews_window_checker.sv
sim/e2e_window_state_machine_unit_tb.sv
